### hw/rtl/range_add_range_sum_blocks_macros.svh
// Assertion macros for the range add / range sum block.
`ifndef RANGE_ADD_RANGE_SUM_BLOCKS_MACROS_SVH
`define RANGE_ADD_RANGE_SUM_BLOCKS_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### hw/rtl/rars_pkg.sv
// Shared constants and types for the range add / range sum block.
`timescale 1ns / 1ps
package rars_pkg;
    localparam int Depth = 1024;
    localparam int BlockSize = 32;
    localparam int NumBlocks = (Depth + BlockSize - 1) / BlockSize;
    localparam int IdxW = 10;
    localparam int AddrW = $clog2(Depth);
    localparam int BlkW = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
    localparam int OffW = $clog2(BlockSize);
    localparam int QDepth = 2;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_SUM = 1'b1;

    // One classified command from the front part to the back part.
    typedef struct packed {
        logic               is_sum;
        logic               valid_range;
        logic [IdxW-1:0]    first;
        logic [IdxW-1:0]    last;
        logic [63:0]        value;
    } cmd_t;
endpackage

### hw/rtl/rars_front.sv
// Front part: accepts request beats, checks the range and queues commands.
`timescale 1ns / 1ps
`include "range_add_range_sum_blocks_macros.svh"
module rars_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [55:0]         s_tdata,
    output logic                q_valid,
    input  logic                q_ready,
    output rars_pkg::cmd_t      q_cmd
);
    import rars_pkg::*;

    cmd_t            mem_reg [QDepth];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      cnt_reg;
    cmd_t            in_cmd;
    logic            push, pop;
    logic [IdxW-1:0] f, l;

    // Decode and classify the beat.
    always_comb
    begin
        f = s_tdata[10:1];
        l = s_tdata[20:11];
        in_cmd.is_sum = s_tdata[0];
        in_cmd.first = f;
        in_cmd.last = l;
        in_cmd.value = {{32{s_tdata[52]}}, s_tdata[52:21]};
        in_cmd.valid_range = (f <= l) && ({1'b0, l} < (IdxW+1)'(Depth));
    end

    assign s_tready = (cnt_reg != 2'(QDepth));
    assign push = s_tvalid && s_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_cmd = mem_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    `ASSERT_IMPLIES(a_cnt_max, clk, rst_n, 1'b1, cnt_reg <= 2'(QDepth))
    `ASSERT_NEXT(a_full_hold, clk, rst_n, (cnt_reg == 2'(QDepth)) && !pop,
        cnt_reg == 2'(QDepth))
    `ASSERT_NEXT(a_empty_hold, clk, rst_n, (cnt_reg == 2'd0) && !push, !q_valid)
endmodule

### hw/rtl/rars_back.sv
// Back part: walks the range over blocks and elements and returns sums.
`timescale 1ns / 1ps
`include "range_add_range_sum_blocks_macros.svh"
module rars_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  rars_pkg::cmd_t      q_cmd,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata
);
    import rars_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_STEP, S_PD_RD, S_PD_WR, S_EL_RD, S_EL_WR, S_OUT
    } state_t;

    logic [63:0]     elem_mem [Depth];
    logic [63:0]     pend_mem [NumBlocks];
    logic [63:0]     tot_mem  [NumBlocks];

    state_t          state_reg;
    cmd_t            cmd_reg;
    logic [IdxW:0]   i_reg;
    logic [63:0]     acc_reg;
    logic [63:0]     pend_reg;
    logic [OffW:0]   pd_cnt_reg;
    logic [AddrW:0]  clr_reg;
    logic [63:0]     rd_reg;
    logic [63:0]     out_reg;
    logic            out_valid_reg;

    logic [BlkW-1:0] blk;
    logic            whole;
    logic [IdxW+1:0] blk_end;
    logic [AddrW-1:0] pd_addr;
    logic            out_load;

    always_comb
    begin
        blk = BlkW'(i_reg >> OffW);
        blk_end = (IdxW+2)'(i_reg) + (IdxW+2)'(BlockSize - 1);
        whole = (i_reg[OffW-1:0] == '0) && (blk_end <= (IdxW+2)'(cmd_reg.last))
            && ((IdxW+2)'(i_reg) + (IdxW+2)'(BlockSize) <= (IdxW+2)'(Depth));
        pd_addr = AddrW'(({{(AddrW-BlkW){1'b0}}, blk} << OffW) + AddrW'(pd_cnt_reg));
    end

    // A finished sum moves into the result register once that register is free.
    assign out_load = (state_reg == S_OUT) && cmd_reg.is_sum && (!out_valid_reg || m_tready);

    assign q_ready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

    // Memory ports; element memory takes one read or one write per cycle, never both.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            elem_mem[AddrW'(clr_reg)] <= 64'd0;
            if (clr_reg < (AddrW+1)'(NumBlocks))
            begin
                pend_mem[BlkW'(clr_reg)] <= 64'd0;
                tot_mem[BlkW'(clr_reg)] <= 64'd0;
            end
        end
        if (state_reg == S_STEP)
        begin
            pend_reg <= pend_mem[blk];
            rd_reg <= tot_mem[blk];
        end
        if (state_reg == S_PD_RD || state_reg == S_EL_RD)
        begin
            rd_reg <= elem_mem[(state_reg == S_PD_RD) ? pd_addr : AddrW'(i_reg)];
        end
        if (state_reg == S_PD_WR)
        begin
            elem_mem[pd_addr] <= rd_reg + pend_reg;
        end
        if (state_reg == S_EL_WR && !cmd_reg.is_sum)
        begin
            elem_mem[AddrW'(i_reg)] <= rd_reg + cmd_reg.value;
            tot_mem[blk] <= tot_mem[blk] + cmd_reg.value;
        end
        if (state_reg == S_PD_RD && pd_cnt_reg == '0)
        begin
            pend_mem[blk] <= 64'd0;
        end
        if (state_reg == S_STEP && i_reg <= (IdxW+1)'(cmd_reg.last) && whole
            && !cmd_reg.is_sum)
        begin
            tot_mem[blk] <= tot_mem[blk] + (cmd_reg.value << OffW);
            pend_mem[blk] <= pend_mem[blk] + cmd_reg.value;
        end
    end

    // Sequencer for one command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            i_reg <= '0;
            acc_reg <= '0;
            pd_cnt_reg <= '0;
            cmd_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            // Result valid: set on a new sum, cleared once the beat is taken.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AddrW+1)'(Depth - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_cmd;
                        i_reg <= {1'b0, q_cmd.first};
                        acc_reg <= '0;
                        state_reg <= q_cmd.valid_range ? S_STEP : S_OUT;
                    end
                end
                S_STEP:
                begin
                    if (i_reg > (IdxW+1)'(cmd_reg.last))
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (whole)
                    begin
                        if (cmd_reg.is_sum) acc_reg <= acc_reg + tot_mem[blk];
                        i_reg <= i_reg + (IdxW+1)'(BlockSize);
                    end
                    else
                    begin
                        pd_cnt_reg <= '0;
                        state_reg <= (pend_mem[blk] != 64'd0) ? S_PD_RD : S_EL_RD;
                    end
                end
                S_PD_RD:
                begin
                    state_reg <= S_PD_WR;
                end
                S_PD_WR:
                begin
                    pd_cnt_reg <= pd_cnt_reg + 1'b1;
                    if (pd_cnt_reg == (OffW+1)'(BlockSize - 1)
                        || (32'(pd_addr) == Depth - 1))
                        state_reg <= S_EL_RD;
                    else
                        state_reg <= S_PD_RD;
                end
                S_EL_RD:
                begin
                    state_reg <= S_EL_WR;
                end
                S_EL_WR:
                begin
                    if (cmd_reg.is_sum) acc_reg <= acc_reg + rd_reg;
                    i_reg <= i_reg + 1'b1;
                    state_reg <= S_STEP;
                end
                S_OUT:
                begin
                    if (!cmd_reg.is_sum)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (!out_valid_reg || m_tready)
                    begin
                        out_reg <= acc_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLIES(a_no_take_busy, clk, rst_n, state_reg != S_IDLE, !q_ready)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && !m_tready,
        out_valid_reg && $stable(out_reg))
    `ASSERT_NEXT(a_pd_pair, clk, rst_n, state_reg == S_PD_RD, state_reg == S_PD_WR)
endmodule

### hw/rtl/range_add_range_sum_blocks.sv
// Top level of the range add / range sum block.
`timescale 1ns / 1ps
// Range add and range sum over 1024 signed 64-bit elements in blocks of 32.
// Request beats are queued two deep; the back part handles one at a time.
// A request takes one step per whole block and a step, a read and a write per
// single element, plus a read and a write per element when a block's pending
// add is pushed down (single-port element memory, one read and one write per
// element). After reset a clearing pass zeroes the memories before the first
// request is taken.
// Add requests give no result beat; sum requests give one.
module range_add_range_sum_blocks (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: first_index[9:0], last_index[9:0], add_value[31:0].
    input  logic [55:0] s_tdata,
    // Fields: req_type.
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields: range_sum[63:0].
    output logic [63:0] m_tdata
);
    import rars_pkg::*;

    logic  q_valid, q_ready;
    cmd_t  q_cmd;
    logic [55:0] packed_in;

    assign packed_in = {3'b000, s_tdata[51:0], s_tuser};

    rars_front u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(packed_in), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    rars_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );
endmodule
